[rtl/core/mhbi_pkg.sv]
`default_nettype none
package mhbi_pkg;

	localparam int ZOOM_LEVELS = 3;
	localparam int RADIX_BITS  = 8;
	localparam int VALUE_BITS  = 32;
	localparam int NDIM        = 5;

	localparam int WIN_W     = 2 * VALUE_BITS;
	localparam int CELL_W    = NDIM * RADIX_BITS;
	localparam int LEVEL_W   = 2;
	localparam int CFG_IDX_W = 4;

	// Bits of the product of the radices below the requested level.
	localparam int PRE_W  = RADIX_BITS * (ZOOM_LEVELS - 1);
	localparam int PROD_W = VALUE_BITS + PRE_W;
	localparam int FRAC_W = VALUE_BITS + RADIX_BITS;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [RADIX_BITS-1:0] radix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KAPPA,
		REG_PHI,
		REG_DCA,
		REG_SLOPE,
		REG_ZOFF,
		REG_LVL0,
		REG_LVL1,
		REG_LVL2
	} reg_idx_t;

endpackage
`default_nettype wire

[rtl/core/mhbi_cfg_if.sv]
`default_nettype none
interface mhbi_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mhbi_pkg::CFG_IDX_W-1:0] index;
	logic [mhbi_pkg::WIN_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/mhbi_in_if.sv]
`default_nettype none
interface mhbi_in_if;
	logic                         valid;
	logic                         ready;
	logic signed [31:0]           curvature;
	logic signed [31:0]           azimuth;
	logic signed [31:0]           impact_dist;
	logic signed [31:0]           dip_slope;
	logic signed [31:0]           z_offset;
	logic [mhbi_pkg::LEVEL_W-1:0] zoom_level;

	modport source (output valid, output curvature, output azimuth, output impact_dist,
		output dip_slope, output z_offset, output zoom_level, input ready);
	modport sink (input valid, input curvature, input azimuth, input impact_dist,
		input dip_slope, input z_offset, input zoom_level, output ready);
endinterface
`default_nettype wire

[rtl/core/mhbi_out_if.sv]
`default_nettype none
interface mhbi_out_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  curvature_bin;
	logic [7:0]                  azimuth_bin;
	logic [7:0]                  impact_bin;
	logic [7:0]                  slope_bin;
	logic [7:0]                  zoff_bin;
	logic [mhbi_pkg::CELL_W-1:0] cell_index;
	logic [4:0]                  range_flags;

	modport source (output valid, output curvature_bin, output azimuth_bin,
		output impact_bin, output slope_bin, output zoff_bin, output cell_index,
		output range_flags, input ready);
	modport sink (input valid, input curvature_bin, input azimuth_bin,
		input impact_bin, input slope_bin, input zoff_bin, input cell_index,
		input range_flags, output ready);
endinterface
`default_nettype wire

[rtl/core/multilevel_hough_bin_index.sv]
`default_nettype none
// Channel | Dir | Handshake   | Moves
// cfg     | in  | valid/ready | register index and 64-bit write data
// cand    | in  | valid/ready | one helix candidate request and zoom level
// res     | out | valid/ready | five bin digits, cell index, range flags
//
// One request enters per cycle while no stalled result holds the pipeline.
// The 32 stages are the window offset, the product with the coarser
// radices, 16 remainder stages of a pipelined divider by the window span, the scaling
// by this level's radix, 8 quotient stages for the digit and 5 cell index fold stages.
// Reset restores the default windows and radices; no clearing pass is needed.
// A stalled result freezes the whole pipeline, so nothing is dropped or repeated.
module multilevel_hough_bin_index (
	input  wire logic clk,
	input  wire logic arst_n,
	mhbi_cfg_if.sink  cfg,
	mhbi_in_if.sink   cand,
	mhbi_out_if.source res
);
	import mhbi_pkg::*;

	// Pipeline positions. Position 0 holds the window offset, position 1 the
	// product with the coarser radices, then the remainder stages, the digit
	// stages and finally the stages that fold the digits into the cell index.
	localparam int P_C0 = PRE_W + RADIX_BITS + 3;
	localparam int NST  = P_C0 + NDIM;

	// One step of restoring division: shift in a bit, subtract when it fits.
	function automatic logic [VALUE_BITS:0] div_step(input value_t rem, input logic b,
			input value_t span);
		logic [VALUE_BITS:0] t;
		t = {rem, b};
		if (t >= {1'b0, span})
			return {1'b1, VALUE_BITS'(t - {1'b0, span})};
		return {1'b0, t[VALUE_BITS-1:0]};
	endfunction

	logic [WIN_W-1:0]  win_q [NDIM];
	logic [CELL_W-1:0] rad_q [ZOOM_LEVELS];

	radix_t            nrad_c [ZOOM_LEVELS][NDIM];
	logic [PRE_W-1:0]  pre_c  [ZOOM_LEVELS][NDIM];
	value_t            span_c [NDIM];
	value_t            val_c  [NDIM];
	value_t            off_c  [NDIM];
	logic [NDIM-1:0]   fl_c;
	logic [LEVEL_W-1:0] lvl_c;
	logic [PROD_W-1:0] prod_c [NDIM];
	logic [FRAC_W-1:0] frac_c [NDIM];
	logic              adv;

	logic [NST-1:0]    v_s;
	logic [NDIM-1:0]   fl_s [NST];
	radix_t            nn_s [NST][NDIM];
	value_t            off_s1 [NDIM];
	logic [PRE_W-1:0]  pre_s1 [NDIM];
	value_t            ra_s [PRE_W+1][NDIM];
	logic [PRE_W-1:0]  la_s [PRE_W+1][NDIM];
	value_t            rb_s [RADIX_BITS+1][NDIM];
	radix_t            lb_s [RADIX_BITS+1][NDIM];
	radix_t            qb_s [RADIX_BITS+1][NDIM];
	radix_t            dg_s [NDIM][NDIM];
	logic [CELL_W-1:0] c_s  [NDIM];

	// Configuration registers; user writes only while the pipeline is empty, unenforced.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NDIM; d++)
				win_q[d] <= {VALUE_BITS'(1) << (VALUE_BITS - 16), VALUE_BITS'(0)};
			for (int l = 0; l < ZOOM_LEVELS; l++)
				rad_q[l] <= {NDIM{RADIX_BITS'(1)}};
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_KAPPA: win_q[0] <= cfg.data;
				REG_PHI:   win_q[1] <= cfg.data;
				REG_DCA:   win_q[2] <= cfg.data;
				REG_SLOPE: win_q[3] <= cfg.data;
				REG_ZOFF:  win_q[4] <= cfg.data;
				REG_LVL0:  rad_q[0] <= cfg.data[CELL_W-1:0];
				REG_LVL1:  rad_q[1] <= cfg.data[CELL_W-1:0];
				REG_LVL2:  rad_q[2] <= cfg.data[CELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Radices with zero read as one, and the running product of the coarser
	// levels' radices for each level.
	always_comb begin
		for (int l = 0; l < ZOOM_LEVELS; l++) begin
			for (int d = 0; d < NDIM; d++) begin
				nrad_c[l][d] = rad_q[l][d*RADIX_BITS +: RADIX_BITS];
				if (nrad_c[l][d] == '0)
					nrad_c[l][d] = RADIX_BITS'(1);
			end
		end
		for (int d = 0; d < NDIM; d++) begin
			pre_c[0][d] = PRE_W'(1);
			for (int l = 1; l < ZOOM_LEVELS; l++)
				pre_c[l][d] = PRE_W'(pre_c[l-1][d] * nrad_c[l-1][d]);
		end
	end

	assign val_c[0] = cand.curvature;
	assign val_c[1] = cand.azimuth;
	assign val_c[2] = cand.impact_dist;
	assign val_c[3] = cand.dip_slope;
	assign val_c[4] = cand.z_offset;

	assign lvl_c = (cand.zoom_level >= LEVEL_W'(ZOOM_LEVELS)) ?
		LEVEL_W'(ZOOM_LEVELS - 1) : cand.zoom_level;

	// Offset from the window minimum; negative or not below the span is out.
	always_comb begin
		logic [VALUE_BITS:0] diff;
		for (int d = 0; d < NDIM; d++) begin
			span_c[d] = win_q[d][VALUE_BITS +: VALUE_BITS];
			diff = {val_c[d][VALUE_BITS-1], val_c[d]} -
				{win_q[d][VALUE_BITS-1], win_q[d][VALUE_BITS-1:0]};
			off_c[d] = diff[VALUE_BITS-1:0];
			fl_c[d] = diff[VALUE_BITS] || (diff[VALUE_BITS-1:0] >= span_c[d]);
			prod_c[d] = PROD_W'(off_s1[d] * pre_s1[d]);
			frac_c[d] = FRAC_W'(ra_s[PRE_W][d] * nn_s[PRE_W+1][d]);
		end
	end

	assign adv       = !v_s[NST-1] || res.ready;
	assign cand.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s <= '0;
		else if (adv)
			v_s <= {v_s[NST-2:0], cand.valid};
	end

	always_ff @(posedge clk) begin
		logic [VALUE_BITS:0] t;
		if (adv) begin
			fl_s[0] <= fl_c;
			for (int d = 0; d < NDIM; d++) begin
				off_s1[d]  <= off_c[d];
				pre_s1[d]  <= pre_c[lvl_c][d];
				nn_s[0][d] <= nrad_c[lvl_c][d];
			end
			for (int p = 1; p < NST; p++) begin
				fl_s[p] <= fl_s[p-1];
				nn_s[p] <= nn_s[p-1];
			end
			for (int d = 0; d < NDIM; d++) begin
				// Remainder of offset times coarser radices over the span.
				ra_s[0][d] <= prod_c[d][PROD_W-1:PRE_W];
				la_s[0][d] <= prod_c[d][PRE_W-1:0];
				for (int k = 1; k <= PRE_W; k++) begin
					t = div_step(ra_s[k-1][d], la_s[k-1][d][PRE_W-1], span_c[d]);
					ra_s[k][d] <= t[VALUE_BITS-1:0];
					la_s[k][d] <= la_s[k-1][d] << 1;
				end
				// The digit is that remainder times this level's radix over the span.
				rb_s[0][d] <= frac_c[d][FRAC_W-1:RADIX_BITS];
				lb_s[0][d] <= frac_c[d][RADIX_BITS-1:0];
				qb_s[0][d] <= '0;
				for (int k = 1; k <= RADIX_BITS; k++) begin
					t = div_step(rb_s[k-1][d], lb_s[k-1][d][RADIX_BITS-1], span_c[d]);
					rb_s[k][d] <= t[VALUE_BITS-1:0];
					lb_s[k][d] <= lb_s[k-1][d] << 1;
					qb_s[k][d] <= {qb_s[k-1][d][RADIX_BITS-2:0], t[VALUE_BITS]};
				end
				dg_s[0][d] <= fl_s[P_C0-1][d] ? '0 : qb_s[RADIX_BITS][d];
			end
			// Horner fold of the digits, z offset digit most significant.
			c_s[0] <= fl_s[P_C0-1][NDIM-1] ? '0 : CELL_W'(qb_s[RADIX_BITS][NDIM-1]);
			for (int j = 1; j < NDIM; j++) begin
				dg_s[j] <= dg_s[j-1];
				c_s[j]  <= CELL_W'(dg_s[j-1][NDIM-1-j]) +
					CELL_W'(c_s[j-1] * CELL_W'(nn_s[P_C0+j-1][NDIM-1-j]));
			end
		end
	end

	assign res.valid         = v_s[NST-1];
	assign res.curvature_bin = dg_s[NDIM-1][0];
	assign res.azimuth_bin   = dg_s[NDIM-1][1];
	assign res.impact_bin    = dg_s[NDIM-1][2];
	assign res.slope_bin     = dg_s[NDIM-1][3];
	assign res.zoff_bin      = dg_s[NDIM-1][4];
	assign res.cell_index    = c_s[NDIM-1];
	assign res.range_flags   = fl_s[NST-1];

	// A dimension outside its window always reports digit zero.
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ((!res.range_flags[0] || res.curvature_bin == '0) &&
			(!res.range_flags[1] || res.azimuth_bin == '0) &&
			(!res.range_flags[2] || res.impact_bin == '0) &&
			(!res.range_flags[3] || res.slope_bin == '0) &&
			(!res.range_flags[4] || res.zoff_bin == '0)))
		else $error("flagged dimension has a nonzero digit");

	// Every digit stays below the radix of its level.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.curvature_bin < nn_s[NST-1][0] &&
			res.azimuth_bin < nn_s[NST-1][1] && res.impact_bin < nn_s[NST-1][2] &&
			res.slope_bin < nn_s[NST-1][3] && res.zoff_bin < nn_s[NST-1][4]))
		else $error("digit not below its radix");

	// A stall freezes the valid bits of all stages.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s))
		else $error("pipeline moved during a stall");

	a_all_out: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.range_flags == 5'h1f) |-> res.cell_index == '0)
		else $error("cell index nonzero with every dimension out of window");

endmodule
`default_nettype wire

[sim/multilevel_hough_bin_index_checker.sv]
`timescale 1ns / 1ps
module multilevel_hough_bin_index_checker (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mhbi_cfg_if         cfg,
	mhbi_in_if          cand,
	mhbi_out_if         res,
	output int unsigned pending,
	output int unsigned fails,
	output int unsigned checked,
	output int unsigned flagged
);
	import mhbi_pkg::*;

	typedef struct packed {
		logic [7:0]        kappa;
		logic [7:0]        phi;
		logic [7:0]        dca;
		logic [7:0]        slope;
		logic [7:0]        zoff;
		logic [CELL_W-1:0] lin_index;
		logic [4:0]        flags;
	} bin_result_t;

	logic [WIN_W-1:0]  window_reg [NDIM];
	logic [CELL_W-1:0] radix_reg [ZOOM_LEVELS];
	bin_result_t       expected_bins [$];

	function automatic longint unsigned radix_at(int lvl, int dim);
		logic [RADIX_BITS-1:0] r;
		r = radix_reg[lvl][dim*RADIX_BITS +: RADIX_BITS];
		return (r == 0) ? 1 : longint'(r);
	endfunction

	function automatic bin_result_t bin_candidate(logic [VALUE_BITS-1:0] v [NDIM],
			logic [LEVEL_W-1:0] zoom);
		bin_result_t       b;
		int                lvl;
		longint            lo, val, off;
		longint unsigned   span, p, dig [NDIM], lin;
		logic [4:0]        fl;
		lvl = (zoom >= ZOOM_LEVELS) ? ZOOM_LEVELS - 1 : int'(zoom);
		fl = '0;
		for (int d = 0; d < NDIM; d++) begin
			lo = longint'($signed(window_reg[d][31:0]));
			span = longint'(window_reg[d][63:32]);
			val = longint'($signed(v[d]));
			off = val - lo;
			dig[d] = 0;
			if (off < 0 || longint'(off) >= longint'(span)) begin
				fl[d] = 1'b1;
			end else begin
				p = 1;
				for (int l = 0; l <= lvl; l++)
					p = p * radix_at(l, d);
				dig[d] = ((longint'(off) * p) / span) % radix_at(lvl, d);
			end
		end
		lin = dig[4];
		for (int d = NDIM - 1; d > 0; d--)
			lin = dig[d-1] + radix_at(lvl, d - 1) * lin;
		b.kappa = dig[0][7:0];
		b.phi   = dig[1][7:0];
		b.dca   = dig[2][7:0];
		b.slope = dig[3][7:0];
		b.zoff  = dig[4][7:0];
		b.lin_index = lin[CELL_W-1:0];
		b.flags = fl;
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [VALUE_BITS-1:0] v [NDIM];
		bin_result_t got, want;
		if (!arst_n) begin
			for (int d = 0; d < NDIM; d++)
				window_reg[d] = 64'h0001_0000_0000_0000;
			for (int l = 0; l < ZOOM_LEVELS; l++)
				radix_reg[l] = 40'h01_0101_0101;
			expected_bins.delete();
			pending = 0;
			fails = 0;
			checked = 0;
			flagged = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_KAPPA, REG_PHI, REG_DCA, REG_SLOPE, REG_ZOFF:
						window_reg[cfg.index] = cfg.data;
					REG_LVL0: radix_reg[0] = cfg.data[CELL_W-1:0];
					REG_LVL1: radix_reg[1] = cfg.data[CELL_W-1:0];
					REG_LVL2: radix_reg[2] = cfg.data[CELL_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got = {res.curvature_bin, res.azimuth_bin, res.impact_bin, res.slope_bin,
					res.zoff_bin, res.cell_index, res.range_flags};
				if (expected_bins.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result %h with nothing outstanding", got);
				end else begin
					want = expected_bins.pop_front();
					checked++;
					if (want.flags != 0)
						flagged++;
					if (got.kappa !== want.kappa || got.phi !== want.phi ||
							got.dca !== want.dca || got.slope !== want.slope ||
							got.zoff !== want.zoff || got.lin_index !== want.lin_index ||
							got.flags !== want.flags) begin
						fails++;
						if (fails <= 10) begin
							$display("bin mismatch: expected bins %h %h %h %h %h cell %h flags %b",
								want.kappa, want.phi, want.dca, want.slope, want.zoff,
								want.lin_index, want.flags);
							$display("              got bins %h %h %h %h %h cell %h flags %b",
								got.kappa, got.phi, got.dca, got.slope, got.zoff,
								got.lin_index, got.flags);
						end
					end
				end
			end
			if (cand.valid && cand.ready) begin
				v[0] = cand.curvature;
				v[1] = cand.azimuth;
				v[2] = cand.impact_dist;
				v[3] = cand.dip_slope;
				v[4] = cand.z_offset;
				expected_bins.push_back(bin_candidate(v, cand.zoom_level));
			end
			pending = expected_bins.size();
		end
	end

endmodule

[sim/multilevel_hough_bin_index_test.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the hierarchical Hough bin indexer.
// The checker beside the block predicts every result from the candidate and the
// register values it saw written, so this module only creates traffic: register
// phases, a short directed set of candidates, then random candidates aimed mostly
// inside the configured windows so that real bin digits and cell indexes appear.
module multilevel_hough_bin_index_test;
	import mhbi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LATENCY = 32;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 205;
	// An index past the last register; the block must ignore writes to it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

	logic clk;
	logic arst_n;
	int unsigned pending, fails, checked, flagged;
	int unsigned cycles = 0;
	bit send_idle_on;
	bit recv_idle_on;

	// Shadow of what has been written, used only to aim candidates at windows.
	logic [WIN_W-1:0] window_set [NDIM];

	mhbi_cfg_if cfg_ch();
	mhbi_in_if  cand_ch();
	mhbi_out_if res_ch();

	multilevel_hough_bin_index dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.cand(cand_ch),
		.res(res_ch)
	);

	multilevel_hough_bin_index_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.cand(cand_ch),
		.res(res_ch),
		.pending(pending),
		.fails(fails),
		.checked(checked),
		.flagged(flagged)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Result side: after each accepted result the sink stalls for a random number
	// of cycles, unless the current phase runs with the sink always ready.
	initial begin
		int unsigned hold;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = recv_idle_on ? $urandom_range(0, 7) : 0;
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (idx < NDIM)
			window_set[idx] = data;
	endtask

	// One candidate request. The valid line is lowered only when a gap follows,
	// so back-to-back requests keep it high without a second assignment.
	task automatic send_candidate(logic [VALUE_BITS-1:0] v [NDIM], logic [LEVEL_W-1:0] zoom);
		int unsigned gap;
		gap = send_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			cand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cand_ch.valid       <= 1'b1;
		cand_ch.curvature   <= v[0];
		cand_ch.azimuth     <= v[1];
		cand_ch.impact_dist <= v[2];
		cand_ch.dip_slope   <= v[3];
		cand_ch.z_offset    <= v[4];
		cand_ch.zoom_level  <= zoom;
		do @(posedge clk); while (!cand_ch.ready);
	endtask

	// Lower valid and hold off until every outstanding result has come back,
	// so that registers can be rewritten with the pipeline empty.
	task automatic drain();
		cand_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_uniform(logic [VALUE_BITS-1:0] x, logic [LEVEL_W-1:0] zoom);
		logic [VALUE_BITS-1:0] v [NDIM];
		for (int d = 0; d < NDIM; d++)
			v[d] = x;
		send_candidate(v, zoom);
	endtask

	function automatic logic [CELL_W-1:0] random_radices();
		logic [CELL_W-1:0] r;
		for (int d = 0; d < NDIM; d++) begin
			case ($urandom_range(0, 9))
				0: r[d*8 +: 8] = 8'd0;
				1: r[d*8 +: 8] = 8'hFF;
				2: r[d*8 +: 8] = 8'($urandom_range(0, 255));
				default: r[d*8 +: 8] = 8'($urandom_range(1, 12));
			endcase
		end
		return r;
	endfunction

	function automatic logic [WIN_W-1:0] random_window();
		logic [31:0] lo, span;
		case ($urandom_range(0, 9))
			0: begin lo = $urandom; span = $urandom; end
			1: begin lo = 32'h8000_0000; span = 32'hFFFF_FFFF; end
			2: begin lo = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000; span = 32'd0; end
			3: begin lo = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000; span = 32'd1; end
			default: begin
				lo   = $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
				span = $urandom_range(1, 32'h0020_0000);
			end
		endcase
		return {span, lo};
	endfunction

	// Pick a value for one dimension: mostly inside its window, some at its
	// borders, the rest anywhere in the 32-bit range.
	function automatic logic [VALUE_BITS-1:0] aim_value(int dim);
		logic [31:0] lo, span;
		logic [63:0] pick;
		lo   = window_set[dim][31:0];
		span = window_set[dim][63:32];
		case ($urandom_range(0, 19))
			0: return lo;
			1: return lo - 1;
			2: return lo + span;
			3: return lo + span - 1;
			4, 5, 6: return $urandom;
			default: begin
				pick = {$urandom, $urandom};
				return (span == 0) ? lo : lo + 32'(pick % span);
			end
		endcase
	endfunction

	initial begin
		logic [VALUE_BITS-1:0] v [NDIM];
		int unsigned random_sent;
		arst_n = 1'b0;
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data  = '0;
		cand_ch.valid = 1'b0;
		cand_ch.curvature = '0;
		cand_ch.azimuth = '0;
		cand_ch.impact_dist = '0;
		cand_ch.dip_slope = '0;
		cand_ch.z_offset = '0;
		cand_ch.zoom_level = '0;
		for (int d = 0; d < NDIM; d++)
			window_set[d] = 64'h0001_0000_0000_0000;
		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset windows and radices: extremes of the value range and every level,
		// including the out-of-range level that must saturate.
		send_uniform(32'h0000_0000, 2'd0);
		send_uniform(32'h0000_FFFF, 2'd1);
		send_uniform(32'h0001_0000, 2'd2);
		send_uniform(32'h7FFF_FFFF, 2'd3);
		send_uniform(32'h8000_0000, 2'd0);
		send_uniform(32'hFFFF_FFFF, 2'd3);
		drain();

		// Directed register set: a negative minimum, a zero span on z offset,
		// a full span on dip slope, zero radices on level 1 and 255 on level 2.
		write_reg(REG_KAPPA, {32'h0002_0000, 32'hFFFF_0000});
		write_reg(REG_PHI,   {32'h0000_0100, 32'h0000_0000});
		write_reg(REG_DCA,   {32'h0000_0007, 32'h7FFF_FFF0});
		write_reg(REG_SLOPE, {32'hFFFF_FFFF, 32'h8000_0000});
		write_reg(REG_ZOFF,  {32'h0000_0000, 32'h0000_0000});
		write_reg(REG_LVL0,  WIN_W'(40'h05_0403_0207));
		write_reg(REG_LVL1,  WIN_W'(40'h00_0000_0000));
		write_reg(REG_LVL2,  WIN_W'(40'hFF_FFFF_FFFF));
		// The spare index must leave every window as it is.
		write_reg(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int lvl = 0; lvl < 4; lvl++) begin
			// Window minimum, last value inside, first value past the end, one below.
			for (int d = 0; d < NDIM; d++)
				v[d] = window_set[d][31:0];
			send_candidate(v, LEVEL_W'(lvl));
			for (int d = 0; d < NDIM; d++)
				v[d] = window_set[d][31:0] + window_set[d][63:32] - 1;
			send_candidate(v, LEVEL_W'(lvl));
			for (int d = 0; d < NDIM; d++)
				v[d] = window_set[d][31:0] + window_set[d][63:32];
			send_candidate(v, LEVEL_W'(lvl));
			for (int d = 0; d < NDIM; d++)
				v[d] = window_set[d][31:0] - 1;
			send_candidate(v, LEVEL_W'(lvl));
		end
		send_uniform(32'h7FFF_FFFF, 2'd2);
		send_uniform(32'h8000_0000, 2'd2);
		drain();

		// Random phases. Each rewrites every register, the first with the widest
		// settings; idling on either side is switched on and off between phases.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			send_idle_on = (ph % 3) != 0;
			recv_idle_on = (ph % 2) != 0;
			for (int d = 0; d < NDIM; d++)
				write_reg(reg_idx_t'(d), (ph == 0) ? {32'hFFFF_FFFF, 32'h8000_0000}
					: random_window());
			write_reg(REG_LVL0, WIN_W'((ph == 0) ? 40'hFF_FFFF_FFFF : random_radices()));
			write_reg(REG_LVL1, WIN_W'((ph == 0) ? 40'hFF_FFFF_FFFF : random_radices()));
			write_reg(REG_LVL2, WIN_W'((ph == 0) ? 40'hFF_FFFF_FFFF : random_radices()));
			if (ph == 3)
				write_reg(REG_SPARE, {$urandom, $urandom});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				for (int d = 0; d < NDIM; d++)
					v[d] = aim_value(d);
				send_candidate(v, LEVEL_W'($urandom_range(0, 3)));
				random_sent++;
				// Halfway through one phase the sender waits for the pipeline to empty.
				if (ph == 2 && i == PHASE_ITEMS / 2)
					drain();
			end
			drain();
		end

		repeat (LATENCY + 8) @(posedge clk);
		$display("Ran %0d random candidates over %0d register phases plus a directed set.",
			random_sent, RANDOM_PHASES);
		$display("Checked %0d results, %0d of them with a dimension outside its window.",
			checked, flagged);
		if (fails == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
